// ===== sv/nebacc_pkg.sv =====
// ----------------------------------------------------------------------------
// nebacc_pkg
// Types and constants of the normal-equation block accumulator.
// ----------------------------------------------------------------------------
package nebacc_pkg;

	localparam int FRAME_N       = 6;
	localparam int POINT_N       = 3;
	localparam int FRAME_ENTRIES = 42;
	localparam int POINT_ENTRIES = 12;
	localparam int BASE_W        = 16;

	localparam logic [2:0] REQ_FRAME_ROW  = 3'd0;
	localparam logic [2:0] REQ_POINT_ROW  = 3'd1;
	localparam logic [2:0] REQ_READ_FRAME = 3'd2;
	localparam logic [2:0] REQ_READ_POINT = 3'd3;
	localparam logic [2:0] REQ_CLR_FRAME  = 3'd4;
	localparam logic [2:0] REQ_CLR_POINT  = 3'd5;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FIXED = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [1:0] CFG_FIXED_FRAMES = 2'd0;
	localparam logic [1:0] CFG_FIXED_POINTS = 2'd1;
	localparam logic [1:0] CFG_WEIGHT_EN    = 2'd2;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [10:0]        entity_id;
		logic [5:0]         elem_index;
		logic signed [31:0] jac_0;
		logic signed [31:0] jac_1;
		logic signed [31:0] jac_2;
		logic signed [31:0] jac_3;
		logic signed [31:0] jac_4;
		logic signed [31:0] jac_5;
		logic signed [31:0] residual;
		logic [16:0]        weight;
	} nebacc_req_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [1:0]         status;
	} nebacc_res_t;

	typedef enum logic [1:0] {
		OP_ACC,
		OP_READ,
		OP_CLEAR
	} nebacc_op_t;

	// One classified item as it waits between front and back
	typedef struct packed {
		nebacc_op_t         op;
		logic               is_frame;
		logic [1:0]         status;
		logic [BASE_W-1:0]  base;
		logic [5:0]         elem;
		logic [5:0][31:0]   jac;
		logic signed [31:0] residual;
		logic [16:0]        weight;
	} nebacc_entry_t;

	typedef enum logic [3:0] {
		BK_INIT,
		BK_IDLE,
		BK_P0,
		BK_P1,
		BK_P2,
		BK_P3,
		BK_RD0,
		BK_RD1,
		BK_ZERO,
		BK_EMIT
	} nebacc_state_t;

endpackage

// ===== sv/nebacc_ram.sv =====
// ----------------------------------------------------------------------------
// nebacc_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module nebacc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/nebacc_front.sv =====
// ----------------------------------------------------------------------------
// nebacc_front
// Classify incoming items and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module nebacc_front #(
	parameter int MAX_FRAMES = 64,
	parameter int MAX_POINTS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  nebacc_pkg::nebacc_req_t req,
	input  logic [9:0]            fixed_frames,
	input  logic [9:0]            fixed_points,
	output logic                  full,
	output logic                  q_valid,
	output nebacc_pkg::nebacc_entry_t q_entry,
	input  logic                  pop
);
	import nebacc_pkg::*;

	nebacc_entry_t ent;
	nebacc_entry_t slot_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          is_frame;
	logic [10:0]   fixed;
	logic [10:0]   slot;
	logic [10:0]   cap;
	logic [5:0]    entries;

	always_comb begin
		is_frame = ~req.req_type[0];
		fixed    = is_frame ? {1'b0, fixed_frames} : {1'b0, fixed_points};
		cap      = is_frame ? 11'(MAX_FRAMES) : 11'(MAX_POINTS);
		entries  = is_frame ? 6'(FRAME_ENTRIES) : 6'(POINT_ENTRIES);
		slot     = req.entity_id - fixed;

		ent.is_frame = is_frame;
		ent.elem     = req.elem_index;
		ent.jac      = {req.jac_5, req.jac_4, req.jac_3, req.jac_2, req.jac_1, req.jac_0};
		ent.residual = req.residual;
		ent.weight   = (req.weight > 17'd65536) ? 17'd65536 : req.weight;
		ent.base     = is_frame ? BASE_W'(slot[9:0] * 16'(FRAME_ENTRIES))
		                        : BASE_W'(slot[9:0] * 16'(POINT_ENTRIES));
		case (req.req_type)
			REQ_FRAME_ROW, REQ_POINT_ROW:   ent.op = OP_ACC;
			REQ_READ_FRAME, REQ_READ_POINT: ent.op = OP_READ;
			default:                        ent.op = OP_CLEAR;
		endcase

		if (req.req_type > REQ_CLR_POINT) begin
			ent.status = ST_RANGE;
		end else if (req.entity_id < fixed) begin
			ent.status = ST_FIXED;
		end else if (slot >= cap) begin
			ent.status = ST_RANGE;
		end else if (ent.op == OP_READ && req.elem_index >= entries) begin
			ent.status = ST_RANGE;
		end else begin
			ent.status = ST_DONE;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_entry = slot_q[rd_ptr_q];

endmodule

// ===== sv/nebacc_back.sv =====
// ----------------------------------------------------------------------------
// nebacc_back
// Carry out queued items: read-modify-write sweeps, reads, clears, and the
// clearing pass over both stores after reset.
// ----------------------------------------------------------------------------
module nebacc_back #(
	parameter int MAX_FRAMES = 64,
	parameter int MAX_POINTS = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      weight_en,
	input  logic                      q_valid,
	input  nebacc_pkg::nebacc_entry_t q_entry,
	output logic                      pop,
	output logic                      clearing,
	output logic                      done,
	output nebacc_pkg::nebacc_res_t   result
);
	import nebacc_pkg::*;

	localparam int FDEPTH = MAX_FRAMES * FRAME_ENTRIES;
	localparam int PDEPTH = MAX_POINTS * POINT_ENTRIES;
	localparam int FA_W   = $clog2(FDEPTH);
	localparam int PA_W   = $clog2(PDEPTH);
	localparam int CDEPTH = (FDEPTH > PDEPTH) ? FDEPTH : PDEPTH;
	localparam int CA_W   = $clog2(CDEPTH);

	nebacc_state_t      state_q, state_d;
	nebacc_entry_t      item_q;
	logic [5:0]         k_q;
	logic [2:0]         a_q, b_q;
	logic               grad_q;
	logic [CA_W-1:0]    clr_q;
	logic signed [63:0] m1_q;
	logic signed [56:0] pa_q, pb_q;
	logic signed [63:0] val_q;
	logic               done_q;
	nebacc_res_t        result_q;

	logic [BASE_W-1:0]  addr;
	logic [FA_W-1:0]    f_addr;
	logic [PA_W-1:0]    p_addr;
	logic               f_we, p_we;
	logic [63:0]        wdata;
	logic [63:0]        f_rdata, p_rdata;
	logic signed [63:0] rdata;
	logic               last_entry, last_hess, weighted;
	logic [2:0]         n_last;
	logic signed [31:0] ja, jb;
	logic signed [63:0] mul_m1;
	logic signed [49:0] mul_rw;
	logic signed [56:0] mul_pa, mul_pb;
	logic signed [81:0] wsum;
	logic signed [63:0] term, sum;

	nebacc_ram #(.WIDTH(64), .DEPTH(FDEPTH)) u_frame_ram (
		.clk(clk), .we(f_we), .waddr(f_addr), .wdata(wdata),
		.raddr(f_addr), .rdata(f_rdata)
	);

	nebacc_ram #(.WIDTH(64), .DEPTH(PDEPTH)) u_point_ram (
		.clk(clk), .we(p_we), .waddr(p_addr), .wdata(wdata),
		.raddr(p_addr), .rdata(p_rdata)
	);

	// Datapath
	always_comb begin
		rdata      = item_q.is_frame ? $signed(f_rdata) : $signed(p_rdata);
		n_last     = item_q.is_frame ? 3'(FRAME_N - 1) : 3'(POINT_N - 1);
		last_entry = item_q.is_frame ? (k_q == 6'(FRAME_ENTRIES - 1))
		                             : (k_q == 6'(POINT_ENTRIES - 1));
		last_hess  = (a_q == n_last) && (b_q == n_last);
		weighted   = grad_q && weight_en;
		ja         = $signed(item_q.jac[a_q]);
		jb         = $signed(item_q.jac[b_q]);
		mul_rw     = item_q.residual * $signed({1'b0, item_q.weight});
		mul_m1     = !grad_q ? ja * jb : (weight_en ? 64'(mul_rw) : ja * item_q.residual);
		mul_pa     = ja * $signed({1'b0, m1_q[23:0]});
		mul_pb     = ja * $signed(m1_q[48:24]);
		wsum       = (82'(pb_q) <<< 24) + 82'(pa_q);
		term       = weighted ? wsum[79:16] : m1_q;
		sum        = rdata + term;
		if (!rdata[63] && !term[63] && sum[63]) begin
			sum = {1'b0, {63{1'b1}}};
		end else if (rdata[63] && term[63] && !sum[63]) begin
			sum = {1'b1, 63'd0};
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_INIT: if (clr_q == CA_W'(CDEPTH - 1)) state_d = BK_IDLE;
			BK_IDLE: begin
				if (q_valid) begin
					if (q_entry.status != ST_DONE) begin
						state_d = BK_EMIT;
					end else begin
						case (q_entry.op)
							OP_ACC:   state_d = BK_P0;
							OP_READ:  state_d = BK_RD0;
							default:  state_d = BK_ZERO;
						endcase
					end
				end
			end
			BK_P0:   state_d = weighted ? BK_P1 : BK_P3;
			BK_P1:   state_d = BK_P2;
			BK_P2:   state_d = BK_P3;
			BK_P3:   state_d = last_entry ? BK_EMIT : BK_P0;
			BK_RD0:  state_d = BK_RD1;
			BK_RD1:  state_d = BK_EMIT;
			BK_ZERO: if (last_entry) state_d = BK_EMIT;
			BK_EMIT: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		pop      = 1'b0;
		clearing = 1'b0;
		f_we     = 1'b0;
		p_we     = 1'b0;
		wdata    = 64'd0;
		addr     = item_q.base + BASE_W'(k_q);
		f_addr   = addr[FA_W-1:0];
		p_addr   = addr[PA_W-1:0];
		case (state_q)
			BK_INIT: begin
				clearing = 1'b1;
				f_addr   = FA_W'(clr_q);
				p_addr   = PA_W'(clr_q);
				f_we     = (32'(clr_q) < FDEPTH);
				p_we     = (32'(clr_q) < PDEPTH);
			end
			BK_IDLE: pop = q_valid;
			BK_P3: begin
				wdata = sum;
				f_we  = item_q.is_frame;
				p_we  = ~item_q.is_frame;
			end
			BK_ZERO: begin
				f_we = item_q.is_frame;
				p_we = ~item_q.is_frame;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				item_q <= q_entry;
				k_q    <= (q_entry.op == OP_READ) ? q_entry.elem : 6'd0;
				a_q    <= 3'd0;
				b_q    <= 3'd0;
				grad_q <= 1'b0;
				val_q  <= 64'sd0;
			end
			BK_P0: m1_q <= mul_m1;
			BK_P1: pa_q <= mul_pa;
			BK_P2: pb_q <= mul_pb;
			BK_P3: begin
				// advance to the next entry: Hessian row-major, then gradient
				k_q <= k_q + 6'd1;
				if (grad_q) begin
					a_q <= a_q + 3'd1;
				end else if (last_hess) begin
					grad_q <= 1'b1;
					a_q    <= 3'd0;
				end else if (b_q == n_last) begin
					b_q <= 3'd0;
					a_q <= a_q + 3'd1;
				end else begin
					b_q <= b_q + 3'd1;
				end
			end
			BK_RD1:  val_q <= rdata;
			BK_ZERO: k_q <= k_q + 6'd1;
			default: ;
		endcase
		result_q.value  <= val_q;
		result_q.status <= item_q.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_INIT;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == BK_EMIT);
			if (state_q == BK_INIT) begin
				clr_q <= clr_q + CA_W'(1);
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== sv/normal_equation_block_accumulator.sv =====
// ----------------------------------------------------------------------------
// normal_equation_block_accumulator
// Accumulates J^T J and J^T r blocks (J^T r weighted when enabled) for frames and points.
// ----------------------------------------------------------------------------
// Steps: a row item sweeps its block through states P0 and P3 per entry,
//   with P1 and P2 between them for a weighted gradient entry; a read passes
//   RD0 and RD1, a clear zeroes each entry, a skipped or rejected item goes to EMIT.
// Throughput: one item at a time in the back end, a two-entry queue takes new
//   items meanwhile; the receiver cannot stall, done is a one-cycle strobe.
// Reset: busy stays high while the clearing pass zeroes every entry of both stores.
module normal_equation_block_accumulator #(
	parameter int MAX_FRAMES = 64,
	parameter int MAX_POINTS = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  nebacc_pkg::nebacc_req_t req,
	output logic                    done,
	output nebacc_pkg::nebacc_res_t result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [1:0]              cfg_index,
	input  logic [9:0]              cfg_data
);
	import nebacc_pkg::*;

	logic          fixed_frames_q_en;
	logic [9:0]    fixed_frames_q, fixed_points_q;
	logic          weight_en_q;
	logic          full, q_valid, pop, clearing, push;
	nebacc_entry_t q_entry;

	// Configuration registers: always ready, indexes past the list are dropped
	assign cfg_ready         = 1'b1;
	assign fixed_frames_q_en = cfg_valid && (cfg_index == CFG_FIXED_FRAMES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_frames_q <= 10'd0;
			fixed_points_q <= 10'd0;
			weight_en_q    <= 1'b0;
		end else begin
			if (fixed_frames_q_en) begin
				fixed_frames_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == CFG_FIXED_POINTS) begin
				fixed_points_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == CFG_WEIGHT_EN) begin
				weight_en_q <= cfg_data[0];
			end
		end
	end

	// Hold off new items while the queue is full or the stores are clearing
	assign busy = full || clearing;
	assign push = start && !busy;

	nebacc_front #(.MAX_FRAMES(MAX_FRAMES), .MAX_POINTS(MAX_POINTS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .req(req),
		.fixed_frames(fixed_frames_q), .fixed_points(fixed_points_q),
		.full(full), .q_valid(q_valid), .q_entry(q_entry), .pop(pop)
	);

	nebacc_back #(.MAX_FRAMES(MAX_FRAMES), .MAX_POINTS(MAX_POINTS)) u_back (
		.clk(clk), .arst_n(arst_n), .weight_en(weight_en_q),
		.q_valid(q_valid), .q_entry(q_entry), .pop(pop), .clearing(clearing),
		.done(done), .result(result)
	);

endmodule

// ===== sv/nebacc_checker.sv =====
// ----------------------------------------------------------------------------
// nebacc_checker
// Port-level checks of the accumulator's result stream and configuration port.
// ----------------------------------------------------------------------------
module nebacc_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    done,
	input nebacc_pkg::nebacc_res_t result,
	input logic                    cfg_ready
);
	import nebacc_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_DONE || result.status == ST_FIXED ||
		          result.status == ST_RANGE))
		else $error("unknown status code");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_DONE) |-> (result.value == 64'sd0))
		else $error("rejected item carries a value");

	a_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on back-to-back cycles");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind normal_equation_block_accumulator nebacc_checker u_nebacc_checker (
	.clk(clk), .arst_n(arst_n),
	.done(done), .result(result), .cfg_ready(cfg_ready)
);
